FILE: rtl/tfr_pkg.sv
// Shared types and constants for the transposed-form FIR ring.
// No dependencies.
`default_nettype none

package tfr_pkg;

	localparam int ACC_W     = 40;
	localparam int COEF_W    = 16;
	localparam int FRAC_BITS = 15;
	localparam int TAP_W     = 8;
	localparam int IDX_W     = 8;

	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_COEF  = 2'd1,
		FUNC_CLEAR = 2'd2
	} func_t;

endpackage

`default_nettype wire

FILE: rtl/tfr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module tfr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/tfr_mac.sv
// Two-stage multiply-accumulate: product register, then add and write-back.
// Depends on tfr_pkg.
`default_nettype none

module tfr_mac #(
	parameter int AW = 8,
	parameter int SW = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 issue,
	input  wire logic [AW-1:0]        issue_slot,
	input  wire tfr_pkg::acc_t        acc_rd,
	input  wire tfr_pkg::coef_t       coef_rd,
	input  wire logic signed [SW-1:0] sample,
	output logic                      wr_en,
	output logic [AW-1:0]             wr_addr,
	output tfr_pkg::acc_t             wr_data,
	output logic                      busy
);

	localparam int PW = tfr_pkg::COEF_W + SW;

	logic                 v_s1;
	logic [AW-1:0]        slot_s1;
	logic                 v_s2;
	logic [AW-1:0]        slot_s2;
	logic signed [PW-1:0] prod_s2;
	tfr_pkg::acc_t        acc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// read data is valid in the s1 cycle
	always_ff @(posedge clk) begin
		slot_s1 <= issue_slot;
		slot_s2 <= slot_s1;
		prod_s2 <= PW'(coef_rd) * PW'(sample);
		acc_s2  <= acc_rd;
	end

	assign wr_en   = v_s2;
	assign wr_addr = slot_s2;
	assign wr_data = acc_s2 + tfr_pkg::acc_t'(prod_s2);
	assign busy    = v_s1 | v_s2;

endmodule

`default_nettype wire

FILE: rtl/transposed_fir_ring.sv
// Transposed-form FIR over a ring of accumulators held in RAM.
// Push sample: tap_len taps issued at one per cycle, then the accumulate pipeline drains,
// then one RAM read and one load; with zero taps it goes straight to the drain. The next
// item is taken only once the block is back in idle. Clear: one accumulator per cycle.
// A stalled result holds the block in its load state. After reset a pass over the ring
// zeroes both RAMs; in_ready stays low meanwhile. Depends on tfr_pkg, tfr_ram, tfr_mac.
`default_nettype none

module transposed_fir_ring #(
	parameter int RING_DEPTH   = 256,
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tfr_pkg::TAP_W-1:0]      tap_len,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     func,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	input  wire logic [tfr_pkg::IDX_W-1:0]      tap_index,
	input  wire logic signed [15:0]             tap_value,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      filtered
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);
	localparam tfr_pkg::acc_t SAT_HI = tfr_pkg::acc_t'((1 << (SAMPLE_WIDTH - 1)) - 1);
	localparam tfr_pkg::acc_t SAT_LO = tfr_pkg::acc_t'(-(1 << (SAMPLE_WIDTH - 1)));

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_TAPS,
		ST_DRAIN,
		ST_LOAD
	} state_t;

	state_t                          state_q;
	logic [AW-1:0]                   sweep_q;
	logic [AW-1:0]                   pos_q;
	logic [AW-1:0]                   slot_q;
	logic [AW-1:0]                   caddr_q;
	logic [tfr_pkg::TAP_W-1:0]       tap_cnt_q;
	logic [tfr_pkg::TAP_W-1:0]       tap_len_q;
	logic signed [SAMPLE_WIDTH-1:0]  sample_q;
	logic signed [SAMPLE_WIDTH-1:0]  out_q;
	logic                            out_valid_q;

	logic                    in_acc;
	logic                    load;
	logic                    acc_we;
	logic [AW-1:0]           acc_waddr;
	tfr_pkg::acc_t           acc_wdata;
	logic                    acc_re;
	logic [AW-1:0]           acc_raddr;
	tfr_pkg::acc_t           acc_rdata;
	logic                    coef_we;
	logic [AW-1:0]           coef_waddr;
	tfr_pkg::coef_t          coef_wdata;
	logic                    coef_re;
	tfr_pkg::coef_t          coef_rdata;
	logic                    mac_wr_en;
	logic [AW-1:0]           mac_wr_addr;
	tfr_pkg::acc_t           mac_wr_data;
	logic                    mac_busy;
	logic [tfr_pkg::IDX_W-1:0] idx_red;
	tfr_pkg::acc_t           shifted;
	logic signed [SAMPLE_WIDTH-1:0] sat;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] a);
		ring_next = (a == LAST) ? '0 : a + 1'b1;
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign cfg_ready = 1'b1;
	assign load      = (state_q == ST_LOAD) && (!out_valid_q || out_ready);

	// tap_index modulo RING_DEPTH by restoring reduction
	always_comb begin
		idx_red = tap_index;
		for (int k = 7; k >= 0; k--) begin
			if (idx_red >= (RING_DEPTH << k)) begin
				idx_red = idx_red - tfr_pkg::IDX_W'(RING_DEPTH << k);
			end
		end
	end

	always_comb begin
		acc_we    = mac_wr_en;
		acc_waddr = mac_wr_addr;
		acc_wdata = mac_wr_data;
		if (state_q == ST_INIT || state_q == ST_CLEAR) begin
			acc_we    = 1'b1;
			acc_waddr = sweep_q;
			acc_wdata = '0;
		end else if (in_acc && func == tfr_pkg::FUNC_PUSH) begin
			acc_we    = 1'b1;
			acc_waddr = pos_q;
			acc_wdata = '0;
		end
	end

	assign acc_re    = (state_q == ST_TAPS) || (state_q == ST_DRAIN && !mac_busy);
	assign acc_raddr = (state_q == ST_TAPS) ? slot_q : pos_q;

	assign coef_we    = (state_q == ST_INIT) || (in_acc && func == tfr_pkg::FUNC_COEF);
	assign coef_waddr = (state_q == ST_INIT) ? sweep_q : AW'(idx_red);
	assign coef_wdata = (state_q == ST_INIT) ? '0 : tap_value;
	assign coef_re    = (state_q == ST_TAPS);

	tfr_ram #(
		.WIDTH(tfr_pkg::ACC_W),
		.DEPTH(RING_DEPTH)
	) u_acc_ram (
		.clk  (clk),
		.we   (acc_we),
		.waddr(acc_waddr),
		.wdata(acc_wdata),
		.re   (acc_re),
		.raddr(acc_raddr),
		.rdata(acc_rdata)
	);

	tfr_ram #(
		.WIDTH(tfr_pkg::COEF_W),
		.DEPTH(RING_DEPTH)
	) u_coef_ram (
		.clk  (clk),
		.we   (coef_we),
		.waddr(coef_waddr),
		.wdata(coef_wdata),
		.re   (coef_re),
		.raddr(caddr_q),
		.rdata(coef_rdata)
	);

	tfr_mac #(
		.AW(AW),
		.SW(SAMPLE_WIDTH)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (state_q == ST_TAPS),
		.issue_slot(slot_q),
		.acc_rd    (acc_rdata),
		.coef_rd   (coef_rdata),
		.sample    (sample_q),
		.wr_en     (mac_wr_en),
		.wr_addr   (mac_wr_addr),
		.wr_data   (mac_wr_data),
		.busy      (mac_busy)
	);

	assign shifted = acc_rdata >>> tfr_pkg::FRAC_BITS;
	always_comb begin
		if (shifted > SAT_HI) begin
			sat = SAMPLE_WIDTH'(SAT_HI);
		end else if (shifted < SAT_LO) begin
			sat = SAMPLE_WIDTH'(SAT_LO);
		end else begin
			sat = SAMPLE_WIDTH'(shifted);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			pos_q       <= '0;
			slot_q      <= '0;
			caddr_q     <= '0;
			tap_cnt_q   <= '0;
			tap_len_q   <= tfr_pkg::TAP_W'(1);
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tap_len_q <= tap_len;
			end
			if (load) begin
				out_valid_q <= 1'b1;
				out_q       <= sat;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					sweep_q <= ring_next(sweep_q);
					if (sweep_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						case (tfr_pkg::func_t'(func))
							tfr_pkg::FUNC_PUSH: begin
								pos_q     <= ring_next(pos_q);
								slot_q    <= ring_next(pos_q);
								caddr_q   <= '0;
								tap_cnt_q <= '0;
								state_q   <= (tap_len_q == '0) ? ST_DRAIN : ST_TAPS;
							end
							tfr_pkg::FUNC_CLEAR: begin
								state_q <= ST_CLEAR;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_TAPS: begin
					slot_q    <= ring_next(slot_q);
					caddr_q   <= ring_next(caddr_q);
					tap_cnt_q <= tap_cnt_q + 1'b1;
					if (tap_cnt_q == tap_len_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!mac_busy) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && func == tfr_pkg::FUNC_PUSH) begin
			sample_q <= sample;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = out_q;

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !mac_busy)
		else $error("accumulate pipeline busy while idle");

	a_mac_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		mac_wr_en |-> (state_q == ST_TAPS || state_q == ST_DRAIN))
		else $error("accumulator write outside tap phase");

	a_load_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && $past(state_q) == ST_DRAIN) |-> $past(acc_re))
		else $error("result load without accumulator read");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST)
		else $error("ring position out of range");

endmodule

`default_nettype wire
